>>> hw/rtl/beeper_tick_sequencer_unit_assert.svh
// Assertion macros used by the beeper tick sequencer RTL.
`ifndef BEEPER_TICK_SEQUENCER_UNIT_ASSERT_SVH
`define BEEPER_TICK_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BTSEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BTSEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/btseq_pkg.sv
// Package with the types and constants of the beeper tick sequencer.
package btseq_pkg;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CMD_W      = 3;
    localparam int unsigned BEEP_W     = 16;
    localparam int unsigned MOD_W      = 7;
    localparam int unsigned QUOT_W     = 10;
    localparam int unsigned FLIP_W     = 11;
    localparam int unsigned MSEC_W     = 10;
    localparam int unsigned MILLIS_W   = 32;
    localparam int unsigned SEC_W      = 6;
    localparam int unsigned MIN_W      = 6;
    localparam int unsigned HOUR_W     = 5;

    // Register reset values.
    localparam logic [CFG_W-1:0] SHORT_TICKS_RST = 16'd150;
    localparam logic [CFG_W-1:0] LONG_TICKS_RST  = 16'd800;
    localparam logic [CFG_W-1:0] BURST_TICKS_RST = 16'd25;

    // Burst countdown fires a beep when its value modulo 100 reaches 50.
    localparam logic [MOD_W-1:0] BURST_PERIOD_M1 = 7'd99;
    localparam logic [MOD_W-1:0] BURST_POINT     = 7'd50;
    localparam logic [MOD_W-1:0] BURST_PERIOD    = 7'd100;
    // floor(x / 100) == (x * 83887) >> 23 for every 16-bit x.
    localparam logic [16:0]      DIV100_MAGIC    = 17'd83887;
    localparam int unsigned      DIV100_SHIFT    = 23;

    // Flip sequence positions.
    localparam logic [FLIP_W-1:0] FLIP_BEEP_A = 11'd1;
    localparam logic [FLIP_W-1:0] FLIP_BEEP_B = 11'd601;
    localparam logic [FLIP_W-1:0] FLIP_BEEP_C = 11'd1201;
    localparam logic [FLIP_W-1:0] FLIP_LAST   = 11'd1501;

    localparam logic [MSEC_W-1:0] MS_PER_SEC   = 10'd1000;
    localparam logic [SEC_W-1:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [MIN_W-1:0]  MIN_PER_HOUR = 6'd60;
    localparam logic [HOUR_W-1:0] HOUR_PER_DAY = 5'd24;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_SHORT = 3'd1,
        CMD_LONG  = 3'd2,
        CMD_FLIP  = 3'd3,
        CMD_BURST = 3'd4,
        CMD_CLOCK = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_TICKS = 2'd0,
        REG_LONG_TICKS  = 2'd1,
        REG_BURST_TICKS = 2'd2
    } t_cfg_reg;

endpackage

>>> hw/rtl/beeper_tick_sequencer_unit.sv
// Top level of the beeper tick sequencer: input register, update logic, result register.
//
// Usage: one command item per transfer on the input channel (i_in_valid, o_in_stall,
// payload i_cmd, i_burst_load, i_flip_window_open). Command 0 is the 500 us tick,
// 1 and 2 request a short or long beep, 3 starts the flip sequence, 4 loads the burst
// countdown and 5 advances the hours:minutes:seconds clock; 6 and 7 change nothing.
// Every command gives exactly one result transfer on the output channel (o_out_valid,
// i_out_stall) carrying the pin level, the millisecond and second flags, the
// millisecond count and the clock fields as they stand after the command.
// An item taken in sits in the input register; when it moves on, its state update is
// applied and its result is loaded into the result register together. Throughput is
// one item per cycle while the receiver does not stall, set by the single update stage;
// the input register takes a new item in the cycle the result register is drained.
// When the receiver stalls, the result holds; the input register still takes one more
// item, then o_in_stall rises until the result moves on.
// Synchronous active-low reset empties both registers, clears all sequencer state
// and loads the beep lengths with 150, 800 and 25 ticks. The register port writes
// one beep length per cycle with i_cfg_wr_en; index 3 is ignored.
module beeper_tick_sequencer_unit
    import btseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Command channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [BEEP_W-1:0]     i_burst_load,
    input  logic                  i_flip_window_open,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_beeper_out,
    output logic                  o_ms_tick,
    output logic                  o_sec_tick,
    output logic [MILLIS_W-1:0]   o_millis_count,
    output logic [SEC_W-1:0]      o_clock_seconds,
    output logic [MIN_W-1:0]      o_clock_minutes,
    output logic [HOUR_W-1:0]     o_clock_hours
);

`include "beeper_tick_sequencer_unit_assert.svh"

    // Beep lengths.
    logic [CFG_W-1:0]    r_short_ticks;
    logic [CFG_W-1:0]    r_long_ticks;
    logic [CFG_W-1:0]    r_burst_ticks;

    // Input register. The quotient of the burst load by 100 is taken here so that
    // the remainder in the update stage only needs a constant multiply and subtract.
    logic                r_in_valid;
    t_cmd                r_in_cmd;
    logic [BEEP_W-1:0]   r_in_load;
    logic                r_in_flip;
    logic [QUOT_W-1:0]   r_in_quot;
    logic [32:0]         w_load_prod;

    // Sequencer state. r_burst_mod tracks r_burst modulo 100 alongside the count.
    logic [BEEP_W-1:0]   r_beep,      n_beep;
    logic [BEEP_W-1:0]   r_burst,     n_burst;
    logic [MOD_W-1:0]    r_burst_mod, n_burst_mod;
    logic [FLIP_W-1:0]   r_flip_pos,  n_flip_pos;
    logic                r_phase,     n_phase;
    logic [MSEC_W-1:0]   r_msec,      n_msec;
    logic [MILLIS_W-1:0] r_millis,    n_millis;
    logic                r_level,     n_level;
    logic [SEC_W-1:0]    r_sec,       n_sec;
    logic [MIN_W-1:0]    r_min,       n_min;
    logic [HOUR_W-1:0]   r_hour,      n_hour;
    logic                n_ms_flag;
    logic                n_sec_flag;

    // Result register.
    logic                r_out_valid;
    logic                r_out_level;
    logic                r_out_ms;
    logic                r_out_sec;
    logic [MILLIS_W-1:0] r_out_millis;
    logic [SEC_W-1:0]    r_out_sec_f;
    logic [MIN_W-1:0]    r_out_min_f;
    logic [HOUR_W-1:0]   r_out_hour_f;

    logic                w_advance;
    logic                w_in_accept;
    logic [BEEP_W-1:0]   w_load_rem;
    logic [MSEC_W-1:0]   w_msec_inc;

    // The held item moves on whenever the result register is empty or being drained.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_load_prod = {17'd0, i_burst_load} * {16'd0, DIV100_MAGIC};
    assign w_load_rem  = r_in_load - BEEP_W'(r_in_quot * BURST_PERIOD);
    assign w_msec_inc  = r_msec + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= SHORT_TICKS_RST;
            r_long_ticks  <= LONG_TICKS_RST;
            r_burst_ticks <= BURST_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SHORT_TICKS: r_short_ticks <= i_cfg_wdata;
                REG_LONG_TICKS:  r_long_ticks  <= i_cfg_wdata;
                REG_BURST_TICKS: r_burst_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_cmd  <= t_cmd'(i_cmd);
            r_in_load <= i_burst_load;
            r_in_flip <= i_flip_window_open;
            r_in_quot <= w_load_prod[DIV100_SHIFT +: QUOT_W];
        end
    end

    always_comb begin
        n_beep      = r_beep;
        n_burst     = r_burst;
        n_burst_mod = r_burst_mod;
        n_flip_pos  = r_flip_pos;
        n_phase     = r_phase;
        n_msec      = r_msec;
        n_millis    = r_millis;
        n_level     = r_level;
        n_sec       = r_sec;
        n_min       = r_min;
        n_hour      = r_hour;
        n_ms_flag   = 1'b0;
        n_sec_flag  = 1'b0;
        unique case (r_in_cmd)
            CMD_TICK: begin
                // Toggle while a beep runs; otherwise drive low, except that the pin
                // keeps its level while the burst count sits on a burst point.
                if (r_beep != '0) begin
                    n_level = ~r_level;
                    n_beep  = r_beep - 1'b1;
                end else if (r_burst == '0 || r_burst_mod != BURST_POINT) begin
                    n_level = 1'b0;
                end
                // A burst point reloads the beep even if one is running.
                if (r_burst != '0) begin
                    n_burst     = r_burst - 1'b1;
                    n_burst_mod = (r_burst_mod == '0) ? BURST_PERIOD_M1
                                                      : r_burst_mod - 1'b1;
                    if (n_burst_mod == BURST_POINT) begin
                        n_beep = r_burst_ticks;
                    end
                end
                if (r_flip_pos != '0) begin
                    if ((r_flip_pos == FLIP_BEEP_A || r_flip_pos == FLIP_BEEP_B ||
                         r_flip_pos == FLIP_BEEP_C) && n_beep == '0) begin
                        n_beep = r_short_ticks;
                    end
                    n_flip_pos = r_flip_pos + 1'b1;
                    if (!r_in_flip || n_flip_pos > FLIP_LAST) begin
                        n_flip_pos = '0;
                    end
                end
                // Every second tick completes a millisecond.
                n_phase = ~r_phase;
                if (r_phase) begin
                    n_millis  = r_millis + 1'b1;
                    n_ms_flag = 1'b1;
                    if (w_msec_inc >= MS_PER_SEC) begin
                        n_msec     = '0;
                        n_sec_flag = 1'b1;
                    end else begin
                        n_msec = w_msec_inc;
                    end
                end
            end
            CMD_SHORT: begin
                if (r_beep == '0) begin
                    n_beep = r_short_ticks;
                end
            end
            CMD_LONG: begin
                if (r_beep == '0) begin
                    n_beep = r_long_ticks;
                end
            end
            CMD_FLIP: begin
                if (r_flip_pos == '0) begin
                    n_flip_pos = FLIP_BEEP_A;
                end
            end
            CMD_BURST: begin
                n_burst     = r_in_load;
                n_burst_mod = w_load_rem[MOD_W-1:0];
            end
            CMD_CLOCK: begin
                n_sec = r_sec + 1'b1;
                if (n_sec >= SEC_PER_MIN) begin
                    n_sec = '0;
                    n_min = r_min + 1'b1;
                    if (n_min >= MIN_PER_HOUR) begin
                        n_min  = '0;
                        n_hour = r_hour + 1'b1;
                        if (n_hour >= HOUR_PER_DAY) begin
                            n_hour = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep      <= '0;
            r_burst     <= '0;
            r_burst_mod <= '0;
            r_flip_pos  <= '0;
            r_phase     <= 1'b0;
            r_msec      <= '0;
            r_millis    <= '0;
            r_level     <= 1'b0;
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
        end else if (w_advance) begin
            r_beep      <= n_beep;
            r_burst     <= n_burst;
            r_burst_mod <= n_burst_mod;
            r_flip_pos  <= n_flip_pos;
            r_phase     <= n_phase;
            r_msec      <= n_msec;
            r_millis    <= n_millis;
            r_level     <= n_level;
            r_sec       <= n_sec;
            r_min       <= n_min;
            r_hour      <= n_hour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_level  <= n_level;
            r_out_ms     <= n_ms_flag;
            r_out_sec    <= n_sec_flag;
            r_out_millis <= n_millis;
            r_out_sec_f  <= n_sec;
            r_out_min_f  <= n_min;
            r_out_hour_f <= n_hour;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_beeper_out    = r_out_level;
    assign o_ms_tick       = r_out_ms;
    assign o_sec_tick      = r_out_sec;
    assign o_millis_count  = r_out_millis;
    assign o_clock_seconds = r_out_sec_f;
    assign o_clock_minutes = r_out_min_f;
    assign o_clock_hours   = r_out_hour_f;

    // The modulo shadow must stay a valid remainder and be zero with an empty count.
    `BTSEQ_ASSERT_NOW(a_burst_mod_ok, i_clk, i_rst_n, 1'b1,
        (r_burst_mod < BURST_PERIOD) && (r_burst != '0 || r_burst_mod == '0),
        "burst modulo shadow out of step with the burst count")

    // The flip sequence never runs past its last position.
    `BTSEQ_ASSERT_NOW(a_flip_range, i_clk, i_rst_n, 1'b1, r_flip_pos <= FLIP_LAST,
        "flip position beyond the end of the sequence")

    // The clock fields stay in range.
    `BTSEQ_ASSERT_NOW(a_clock_range, i_clk, i_rst_n, 1'b1,
        (r_sec < SEC_PER_MIN) && (r_min < MIN_PER_HOUR) && (r_hour < HOUR_PER_DAY),
        "clock field out of range")

    // A tick on the odd half-millisecond must report a completed millisecond.
    `BTSEQ_ASSERT_NEXT(a_ms_flag, i_clk, i_rst_n,
        w_advance && (r_in_cmd == CMD_TICK) && r_phase,
        o_out_valid && o_ms_tick,
        "millisecond flag missing on the second tick of a millisecond")

    // A second is only ever completed together with a millisecond.
    `BTSEQ_ASSERT_NOW(a_sec_implies_ms, i_clk, i_rst_n, o_out_valid && o_sec_tick,
        o_ms_tick, "second flag without millisecond flag")

endmodule
